>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL. Empty in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every rising edge outside reset
`define PSLIM_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("pslim assertion failed");

// cond must never be true outside reset
`define PSLIM_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("pslim forbidden condition seen");

`else

`define PSLIM_ASSERT(lbl, clk, rst_n, prop)
`define PSLIM_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

>>> sv/pslim_pkg.sv
package pslim_pkg;

	localparam int PSLIM_BUCKETS = 256;
	localparam int PSLIM_WAYS    = 4;

	localparam int ADDR_W  = 32;
	localparam int COUNT_W = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic CMD_CONNECT    = 1'b0;
	localparam logic CMD_DISCONNECT = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_TOTAL      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PER_SOURCE = 2'd1;

	typedef enum logic [2:0] {
		VERDICT_ACCEPT  = 3'd0,
		VERDICT_TOTAL   = 3'd1,
		VERDICT_SOURCE  = 3'd2,
		VERDICT_FULL    = 3'd3,
		VERDICT_RELEASE = 3'd4,
		VERDICT_UNKNOWN = 3'd5
	} verdict_t;

	// one way of a bucket row
	typedef struct packed {
		logic               valid;
		logic [ADDR_W-1:0]  address;
		logic [COUNT_W-1:0] count;
	} slot_t;

	// decision for one event, from the check logic to the sequencer
	typedef struct packed {
		verdict_t           verdict;
		logic [COUNT_W-1:0] total;
		logic [COUNT_W-1:0] source;
		logic               wr;
	} decide_t;

endpackage

>>> sv/per_source_connection_limiter.sv
// channel   dir  handshake            payload
// in        in   in_valid/in_stall    command, src_address
// out       out  out_valid/out_stall  verdict, total_now, source_now
// cfg       in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One event at a time: accept, bucket map, row read, check and write back.
// Events take longer when BUCKETS is not a power of two; the remainder
// unit (one byte per cycle) sets the difference.
// After reset the table is swept clear, one bucket row per cycle; no
// event is taken meanwhile, config writes are.
// A finished beat waits in the output register; the next event is taken
// while it waits, and the check step holds only if that register is full.
module per_source_connection_limiter #(
	parameter int BUCKETS = pslim_pkg::PSLIM_BUCKETS,
	parameter int WAYS    = pslim_pkg::PSLIM_WAYS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             command,
	input  logic [pslim_pkg::ADDR_W-1:0]     src_address,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [2:0]                       verdict,
	output logic [pslim_pkg::COUNT_W-1:0]    total_now,
	output logic [pslim_pkg::COUNT_W-1:0]    source_now,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pslim_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pslim_pkg::COUNT_W-1:0]    cfg_data
);

	import pslim_pkg::*;

	`include "assert_macros.svh"

	localparam int BKT_W = $clog2(BUCKETS);
	localparam int ROW_W = WAYS * $bits(slot_t);

	// sequencer: CLEAR sweeps the table, HASH waits for the bucket and
	// issues the row read, CHECK decides and writes the row back
	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_HASH  = 4'b0100,
		ST_CHECK = 4'b1000
	} state_t;

	state_t state_q, state_d;

	logic [COUNT_W-1:0] max_total_q, max_src_q, live_total_q;
	logic [BKT_W-1:0]   clr_idx_q;
	logic               cmd_q;
	logic [ADDR_W-1:0]  addr_q;

	logic               out_valid_q;
	verdict_t           verdict_q;
	logic [COUNT_W-1:0] total_now_q, source_now_q;

	logic               in_acc, map_done, out_free, commit;
	logic [BKT_W-1:0]   bucket;

	logic               ram_we, ram_re;
	logic [BKT_W-1:0]   ram_waddr;
	logic [ROW_W-1:0]   ram_wdata, ram_rdata;

	slot_t [WAYS-1:0]   row_rd, row_wr;
	decide_t            dec;

	// config port never backs up
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_total_q <= '0;
			max_src_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MAX_TOTAL:      max_total_q <= cfg_data;
				REG_MAX_PER_SOURCE: max_src_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign commit   = (state_q == ST_CHECK) && out_free;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q  <= command;
			addr_q <= src_address;
		end
	end

	pslim_bucket_map #(
		.BUCKETS (BUCKETS)
	) u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (in_acc),
		.address (src_address),
		.done    (map_done),
		.bucket  (bucket)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_idx_q == BKT_W'(BUCKETS - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (in_acc) state_d = ST_HASH;
			ST_HASH:  if (map_done) state_d = ST_CHECK;
			ST_CHECK: if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
		end
	end

	// Row read in HASH, write-back in CHECK: the next read of any row is only
	// issued after a pass through IDLE and HASH, so same-row accesses never overlap.
	assign ram_re    = (state_q == ST_HASH) && map_done;
	assign ram_we    = (state_q == ST_CLEAR) || (commit && dec.wr);
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_idx_q : bucket;
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 : row_wr;
	assign row_rd    = ram_rdata;

	pslim_ram #(
		.WIDTH (ROW_W),
		.DEPTH (BUCKETS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (bucket),
		.rdata (ram_rdata)
	);

	pslim_decide #(
		.WAYS (WAYS)
	) u_decide (
		.row_rd         (row_rd),
		.command        (cmd_q),
		.address        (addr_q),
		.live_total     (live_total_q),
		.max_total      (max_total_q),
		.max_per_source (max_src_q),
		.row_wr         (row_wr),
		.dec            (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_total_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (commit) begin
				live_total_q <= dec.total;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			verdict_q    <= dec.verdict;
			total_now_q  <= dec.total;
			source_now_q <= dec.source;
		end
	end

	assign out_valid  = out_valid_q;
	assign verdict    = verdict_q;
	assign total_now  = total_now_q;
	assign source_now = source_now_q;

	`PSLIM_NEVER(a_no_rw_overlap, clk, arst_n, ram_we && ram_re)
	`PSLIM_ASSERT(a_accept_to_hash, clk, arst_n, in_acc |=> state_q == ST_HASH)
	`PSLIM_ASSERT(a_check_holds, clk, arst_n, (state_q == ST_CHECK && !out_free) |=> (state_q == ST_CHECK && out_valid_q))
	`PSLIM_ASSERT(a_total_only_on_commit, clk, arst_n, !$stable(live_total_q) |-> $past(commit))

endmodule

>>> sv/pslim_ram.sv
module pslim_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> sv/pslim_bucket_map.sv
// bucket = address mod BUCKETS
// power of two: mask, ready in the cycle after start
// otherwise: 8 restoring remainder steps per cycle, one address byte at a time
module pslim_bucket_map #(
	parameter int BUCKETS = pslim_pkg::PSLIM_BUCKETS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pslim_pkg::ADDR_W-1:0]  address,
	output logic                          done,
	output logic [$clog2(BUCKETS)-1:0]    bucket
);

	import pslim_pkg::*;

	localparam int  BKT_W   = $clog2(BUCKETS);
	localparam bit  IS_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;
	localparam int  DIGIT_W = 8;
	localparam int  STEPS   = ADDR_W / DIGIT_W;
	localparam int  STEP_W  = $clog2(STEPS + 1);

	logic [BKT_W-1:0] rem_q;
	logic             done_q;

	generate
		if (IS_POW2) begin : g_mask
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else if (start) begin
					done_q <= 1'b1;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					rem_q <= address[BKT_W-1:0];
				end
			end
		end else begin : g_fold
			logic [ADDR_W-1:0] word_q;
			logic [STEP_W-1:0] left_q;
			logic [BKT_W-1:0]  rem_next;

			// fold one byte into the running remainder, msb first
			always_comb begin
				logic [BKT_W:0] t;
				rem_next = rem_q;
				for (int i = DIGIT_W - 1; i >= 0; i--) begin
					t = {rem_next, word_q[ADDR_W-DIGIT_W+i]};
					if (t >= (BKT_W+1)'(BUCKETS)) begin
						t = t - (BKT_W+1)'(BUCKETS);
					end
					rem_next = t[BKT_W-1:0];
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
					left_q <= '0;
				end else if (start) begin
					done_q <= 1'b0;
					left_q <= STEP_W'(STEPS);
				end else if (left_q != '0) begin
					left_q <= left_q - 1'b1;
					done_q <= (left_q == STEP_W'(1));
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					rem_q  <= '0;
					word_q <= address;
				end else if (left_q != '0) begin
					rem_q  <= rem_next;
					word_q <= word_q << DIGIT_W;
				end
			end
		end
	endgenerate

	assign done   = done_q;
	assign bucket = rem_q;

endmodule

>>> sv/pslim_decide.sv
// way match, limit checks and row update for one event
module pslim_decide #(
	parameter int WAYS = pslim_pkg::PSLIM_WAYS
) (
	input  pslim_pkg::slot_t [WAYS-1:0]          row_rd,
	input  logic                                 command,
	input  logic [pslim_pkg::ADDR_W-1:0]         address,
	input  logic [pslim_pkg::COUNT_W-1:0]        live_total,
	input  logic [pslim_pkg::COUNT_W-1:0]        max_total,
	input  logic [pslim_pkg::COUNT_W-1:0]        max_per_source,
	output pslim_pkg::slot_t [WAYS-1:0]          row_wr,
	output pslim_pkg::decide_t                   dec
);

	import pslim_pkg::*;

	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

	logic               hit_any, free_any;
	logic [WAY_W-1:0]   hit_idx, free_idx, sel_idx;
	logic [COUNT_W-1:0] cur;

	// lowest matching way and lowest free way
	always_comb begin
		hit_any  = 1'b0;
		free_any = 1'b0;
		hit_idx  = '0;
		free_idx = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (row_rd[w].valid && row_rd[w].address == address) begin
				hit_any = 1'b1;
				hit_idx = WAY_W'(w);
			end
			if (!row_rd[w].valid) begin
				free_any = 1'b1;
				free_idx = WAY_W'(w);
			end
		end
	end

	assign cur     = hit_any ? row_rd[hit_idx].count : '0;
	assign sel_idx = hit_any ? hit_idx : free_idx;

	always_comb begin
		logic [COUNT_W-1:0] dec_cnt;
		row_wr      = row_rd;
		dec.verdict = VERDICT_ACCEPT;
		dec.total   = live_total;
		dec.source  = cur;
		dec.wr      = 1'b0;
		dec_cnt     = (cur != '0) ? cur - 1'b1 : '0;
		if (command == CMD_CONNECT) begin
			priority if (!hit_any && !free_any) begin
				dec.verdict = VERDICT_FULL;
			end else if (live_total == COUNT_MAX ||
			             (max_total != '0 && live_total >= max_total)) begin
				dec.verdict = VERDICT_TOTAL;
			end else if (cur == COUNT_MAX ||
			             (max_per_source != '0 && cur >= max_per_source)) begin
				dec.verdict = VERDICT_SOURCE;
			end else begin
				dec.verdict             = VERDICT_ACCEPT;
				dec.total               = live_total + 1'b1;
				dec.source              = cur + 1'b1;
				dec.wr                  = 1'b1;
				row_wr[sel_idx].valid   = 1'b1;
				row_wr[sel_idx].address = address;
				row_wr[sel_idx].count   = cur + 1'b1;
			end
		end else begin
			if (!hit_any) begin
				dec.verdict = VERDICT_UNKNOWN;
				dec.source  = '0;
			end else begin
				dec.verdict           = VERDICT_RELEASE;
				dec.total             = (live_total != '0) ? live_total - 1'b1 : '0;
				dec.source            = dec_cnt;
				dec.wr                = 1'b1;
				row_wr[hit_idx].count = dec_cnt;
				row_wr[hit_idx].valid = (dec_cnt != '0);
			end
		end
	end

endmodule
